// ===== rtl/pem_base64_extractor_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the PEM base64 extractor
// Each macro expects clk and arst_n to be visible in the using module.
// ---------------------------------------------------------------------------
`ifndef PEM_BASE64_EXTRACTOR_DEFINES_SVH
`define PEM_BASE64_EXTRACTOR_DEFINES_SVH

// same-cycle implication, quiet during reset
`define PEM_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, quiet during reset
`define PEM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/pem_b64_pkg.sv =====
// ---------------------------------------------------------------------------
// pem_b64_pkg
// Shared types, codes and character tables for the PEM base64 extractor.
// ---------------------------------------------------------------------------
package pem_b64_pkg;

	// parser phase; codes above PH_WAIT are never reached and act as idle
	typedef enum logic [3:0] {
		PH_INIT = 4'd0,
		PH_IDLE = 4'd1,
		PH_LINE = 4'd2,
		PH_HEAD = 4'd3,
		PH_Q0   = 4'd4,
		PH_Q1   = 4'd5,
		PH_Q2   = 4'd6,
		PH_Q3   = 4'd7,
		PH_WAIT = 4'd8
	} phase_t;

	// escape decoder phase
	typedef enum logic [1:0] {
		ESC_NONE   = 2'd0,
		ESC_FIRST  = 2'd1,
		ESC_SECOND = 2'd2
	} esc_t;

	// result event codes
	typedef enum logic [1:0] {
		EV_BYTE   = 2'd0,
		EV_OK     = 2'd1,
		EV_NOCERT = 2'd2,
		EV_BAD    = 2'd3
	} event_t;

	// one result beat from the parser
	typedef struct packed {
		logic       hit;
		logic [7:0] data;
		event_t     ev;
	} res_t;

	localparam logic [7:0] CHAR_NL   = 8'h0A;
	localparam logic [7:0] CHAR_PCT  = 8'h25;
	localparam logic [7:0] CHAR_DASH = 8'h2D;
	localparam logic [3:0] TAG_LAST  = 4'd10;

	// "-----BEGIN " by position
	function automatic logic [7:0] armor_tag(input logic [3:0] idx);
		logic [7:0] ch;
		case (idx)
			4'd5:    ch = 8'h42; // B
			4'd6:    ch = 8'h45; // E
			4'd7:    ch = 8'h47; // G
			4'd8:    ch = 8'h49; // I
			4'd9:    ch = 8'h4E; // N
			4'd10:   ch = 8'h20; // space
			default: ch = CHAR_DASH;
		endcase
		return ch;
	endfunction

	// base64 alphabet: {valid, sextet}
	function automatic logic [6:0] sextet(input logic [7:0] c);
		logic [6:0] r;
		r = 7'd0;
		if (c >= 8'h41 && c <= 8'h5A)
			r = {1'b1, 6'(c - 8'h41)};
		else if (c >= 8'h61 && c <= 8'h7A)
			r = {1'b1, 6'(c - 8'h61 + 8'd26)};
		else if (c >= 8'h30 && c <= 8'h39)
			r = {1'b1, 6'(c - 8'h30 + 8'd52)};
		else if (c == 8'h2B)
			r = {1'b1, 6'd62};
		else if (c == 8'h2F)
			r = {1'b1, 6'd63};
		return r;
	endfunction

	// hex digit, either case: {valid, nibble}
	function automatic logic [4:0] hexval(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39)
			r = {1'b1, 4'(c - 8'h30)};
		else if (c >= 8'h41 && c <= 8'h46)
			r = {1'b1, 4'(c - 8'h41 + 8'd10)};
		else if (c >= 8'h61 && c <= 8'h66)
			r = {1'b1, 4'(c - 8'h61 + 8'd10)};
		return r;
	endfunction

endpackage

// ===== rtl/pem_b64_core.sv =====
// ---------------------------------------------------------------------------
// pem_b64_core
// Parser state and the combinational step: escape decode, armor header
// match, base64 quartet assembly and completion codes.
// ---------------------------------------------------------------------------
module pem_b64_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [7:0]        char_s1,
	input  logic              eos_s1,
	input  logic              escaped_mode,
	output pem_b64_pkg::res_t res
);
	import pem_b64_pkg::*;
	`include "pem_base64_extractor_defines.svh"

	phase_t     phase_q, phase_d;
	logic [3:0] hidx_q, hidx_d;
	logic [7:0] pbits_q, pbits_d;
	esc_t       esc_q, esc_d;
	logic [7:0] fhc_q, fhc_d;
	logic       skip_q, skip_d;

	// one parse step
	always_comb begin
		logic [7:0] c;
		logic       esc_char;
		logic       go;
		logic [4:0] hi;
		logic [4:0] lo;
		logic [6:0] sx;
		logic [1:0] code;
		logic       fin;

		phase_d  = phase_q;
		hidx_d   = hidx_q;
		pbits_d  = pbits_q;
		esc_d    = esc_q;
		fhc_d    = fhc_q;
		skip_d   = skip_q;
		res.hit  = 1'b0;
		res.data = 8'd0;
		res.ev   = EV_BYTE;
		c        = char_s1;
		esc_char = 1'b0;
		go       = 1'b0;
		hi       = hexval(fhc_q);
		lo       = hexval(char_s1);
		sx       = sextet(char_s1);
		code     = EV_BAD;
		fin      = 1'b0;

		if (eos_s1) begin
			fin = 1'b1;
			if (skip_q)
				code = EV_BAD;
			else if (phase_q == PH_INIT)
				code = EV_NOCERT;
			else if (phase_q == PH_WAIT)
				code = EV_OK;
			else
				code = EV_BAD;
		end else if (skip_q) begin
			if (char_s1 == CHAR_NL) begin
				fin  = 1'b1;
				code = EV_BAD;
			end
		end else if (esc_q == ESC_FIRST) begin
			fhc_d = char_s1;
			esc_d = ESC_SECOND;
		end else if (esc_q == ESC_SECOND) begin
			esc_d = ESC_NONE;
			if (!hi[4] || !lo[4]) begin
				skip_d = 1'b1;
			end else begin
				c        = {hi[3:0], lo[3:0]};
				esc_char = 1'b1;
				go       = 1'b1;
			end
		end else if (escaped_mode && char_s1 == CHAR_PCT) begin
			esc_d = ESC_FIRST;
		end else if (escaped_mode && char_s1 == CHAR_NL) begin
			fin  = 1'b1;
			code = (phase_q == PH_WAIT) ? EV_OK : EV_BAD;
		end else begin
			go = 1'b1;
		end

		// escaped characters are re-coded, so look them up again
		if (esc_char)
			sx = sextet(c);

		if (go) begin
			case (phase_q)
				PH_INIT, PH_LINE: begin
					if (hidx_q > TAG_LAST || c != armor_tag(hidx_q))
						phase_d = PH_IDLE;
					else if (hidx_q == TAG_LAST)
						phase_d = PH_HEAD;
					else begin
						hidx_d  = hidx_q + 4'd1;
						phase_d = PH_LINE;
					end
				end
				PH_HEAD: begin
					if (c == CHAR_NL)
						phase_d = PH_Q0;
				end
				PH_Q0, PH_Q1, PH_Q2, PH_Q3: begin
					if (c == CHAR_DASH) begin
						phase_d = PH_WAIT;
					end else if (sx[6]) begin
						case (phase_q)
							PH_Q0: begin
								pbits_d = {sx[5:0], 2'b00};
								phase_d = PH_Q1;
							end
							PH_Q1: begin
								res.hit  = 1'b1;
								res.data = pbits_q | {6'd0, sx[5:4]};
								pbits_d  = {sx[3:0], 4'd0};
								phase_d  = PH_Q2;
							end
							PH_Q2: begin
								res.hit  = 1'b1;
								res.data = pbits_q | {4'd0, sx[5:2]};
								pbits_d  = {sx[1:0], 6'd0};
								phase_d  = PH_Q3;
							end
							default: begin
								res.hit  = 1'b1;
								res.data = pbits_q | {2'd0, sx[5:0]};
								pbits_d  = 8'd0;
								phase_d  = PH_Q0;
							end
						endcase
					end
				end
				PH_WAIT: begin
					if (c == CHAR_NL && !esc_char) begin
						fin  = 1'b1;
						code = EV_OK;
					end
				end
				default: begin
					if (c == CHAR_NL) begin
						phase_d = PH_LINE;
						hidx_d  = 4'd0;
					end
				end
			endcase
		end

		// completion: report and return to the initial state
		if (fin) begin
			res.hit  = 1'b1;
			res.data = 8'd0;
			res.ev   = event_t'(code);
			phase_d  = PH_INIT;
			hidx_d   = 4'd0;
			pbits_d  = 8'd0;
			esc_d    = ESC_NONE;
			fhc_d    = 8'd0;
			skip_d   = 1'b0;
		end
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_INIT;
			hidx_q  <= 4'd0;
			pbits_q <= 8'd0;
			esc_q   <= ESC_NONE;
			fhc_q   <= 8'd0;
			skip_q  <= 1'b0;
		end else if (step) begin
			phase_q <= phase_d;
			hidx_q  <= hidx_d;
			pbits_q <= pbits_d;
			esc_q   <= esc_d;
			fhc_q   <= fhc_d;
			skip_q  <= skip_d;
		end
	end

	`PEM_ASSERT_NEXT(a_done_clears, step && res.hit && res.ev != EV_BYTE, phase_q == PH_INIT && esc_q == ESC_NONE && !skip_q, "completion did not clear the parser")
	`PEM_ASSERT_NOW(a_byte_in_body, step && res.hit && res.ev == EV_BYTE, phase_q == PH_Q1 || phase_q == PH_Q2 || phase_q == PH_Q3, "byte emitted outside the body")
	`PEM_ASSERT_NOW(a_skip_no_esc, skip_q, esc_q == ESC_NONE, "escape pending while skipping a line")

endmodule

// ===== rtl/pem_b64_outreg.sv =====
// ---------------------------------------------------------------------------
// pem_b64_outreg
// Result register on the output channel; refills in the cycle it drains.
// ---------------------------------------------------------------------------
module pem_b64_outreg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  pem_b64_pkg::res_t res,
	output logic              can_take,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [7:0]        data_byte,
	output logic [1:0]        event_res
);
	import pem_b64_pkg::*;

	logic       valid_q;
	logic [7:0] data_q;
	event_t     ev_q;

	assign can_take  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign data_byte = data_q;
	assign event_res = ev_q;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (step && res.hit) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (step && res.hit) begin
			data_q <= res.data;
			ev_q   <= res.ev;
		end
	end

endmodule

// ===== rtl/pem_base64_extractor.sv =====
// ---------------------------------------------------------------------------
// pem_base64_extractor
// Finds a PEM armor header in a character stream and base64-decodes the
// body, one character per beat, with optional percent-escape decoding.
// ---------------------------------------------------------------------------
//  channel | signals                            | beat
//  --------+------------------------------------+------------------------------
//  in      | in_valid/in_ready                  | char_in, end_of_stream
//  out     | out_valid/out_ready                | data_byte, event_res
//  cfg     | cfg_wr_en                          | cfg_wr_data (escaped mode)
//
// One input beat per cycle; the input stage holds while the result register
// is full and not drained. Beats are registered in the input stage and the
// shallow combinational parser step feeds the result register. Reset clears the
// parser, the valid flags and the escaped-mode register. The user must write
// escaped mode only while no beat is in flight; the block does not enforce it.
// ---------------------------------------------------------------------------
module pem_base64_extractor (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] char_in,
	input  logic       end_of_stream,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] data_byte,
	output logic [1:0] event_res,
	input  logic       cfg_wr_en,
	input  logic       cfg_wr_data
);
	import pem_b64_pkg::*;

	logic       valid_s1;
	logic [7:0] char_s1;
	logic       eos_s1;
	logic       mode_q;
	logic       can_take;
	logic       step;
	res_t       res;

	assign step     = valid_s1 && can_take;
	assign in_ready = !valid_s1 || step;

	// escaped-mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
		end else if (cfg_wr_en) begin
			mode_q <= cfg_wr_data;
		end
	end

	// input stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// input stage payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			char_s1 <= char_in;
			eos_s1  <= end_of_stream;
		end
	end

	pem_b64_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (step),
		.char_s1      (char_s1),
		.eos_s1       (eos_s1),
		.escaped_mode (mode_q),
		.res          (res)
	);

	pem_b64_outreg u_outreg (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.res       (res),
		.can_take  (can_take),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.data_byte (data_byte),
		.event_res (event_res)
	);

endmodule

// ===== tb/tb_pem_base64_extractor.sv =====
// ----------------------------------------------------------------------------
// tb_pem_base64_extractor
// Self-checking bench for the PEM armor base64 extractor. A scoreboard keeps
// its own copy of the parser and the escaped-mode flag. It predicts the bytes
// and completion events that each accepted character beat causes, and checks
// the output beats in order. Stimulus is a short directed run followed by
// random phases: mostly well-formed armored blocks with random bodies and
// escaping, plus noise and broken sequences. Escaped mode alternates between
// phases. Both handshakes idle at random, and one long receiver hold-off
// fills the block so that it stalls its input.
// ----------------------------------------------------------------------------
module tb_pem_base64_extractor;
	timeunit 1ns;
	timeprecision 1ps;

	import pem_b64_pkg::*;

	localparam string ARMOR_HDR        = "-----BEGIN ";
	localparam int    SETTLE_CYCLES    = 8;
	localparam int    HOLD_OFF_CYCLES  = 80;
	localparam int    WATCHDOG_LIMIT   = 2000;
	localparam int    RAND_PHASE_BEATS = 75;

	typedef struct packed {
		logic [7:0] data;
		event_t     ev;
	} cert_res_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       eos;
	} char_beat_t;

	// parser copy and queue of results still owed by the block
	class cert_scoreboard;
		bit         esc_mode;
		phase_t     phase;
		logic [3:0] tag_idx;
		logic [7:0] acc_bits;
		esc_t       esc_ph;
		logic [7:0] esc_hi_ch;
		bit         skipping;
		cert_res_t  pending_results[$];
		int         errors;

		function new();
			esc_mode = 1'b0;
			errors   = 0;
			restart_parse();
		endfunction

		function void restart_parse();
			phase     = PH_INIT;
			tag_idx   = 4'd0;
			acc_bits  = 8'h00;
			esc_ph    = ESC_NONE;
			esc_hi_ch = 8'h00;
			skipping  = 1'b0;
		endfunction

		function void complete(event_t ev);
			restart_parse();
			pending_results.push_back('{data: 8'h00, ev: ev});
		endfunction

		function void emit(logic [7:0] b);
			pending_results.push_back('{data: b, ev: EV_BYTE});
		endfunction

		function int b64_index(logic [7:0] c);
			if (c >= "A" && c <= "Z") return c - "A";
			if (c >= "a" && c <= "z") return c - "a" + 26;
			if (c >= "0" && c <= "9") return c - "0" + 52;
			if (c == "+") return 62;
			if (c == "/") return 63;
			return -1;
		endfunction

		function int hex_nibble(logic [7:0] c);
			if (c >= "0" && c <= "9") return c - "0";
			if (c >= "A" && c <= "F") return c - "A" + 10;
			if (c >= "a" && c <= "f") return c - "a" + 10;
			return -1;
		endfunction

		// advance the parser by one accepted beat, queueing what it yields
		function void note_char(logic [7:0] ch, bit eos);
			logic [7:0] c;
			logic [5:0] v;
			int         sx;
			int         hi;
			int         lo;
			bit         from_esc;
			from_esc = 1'b0;
			if (eos) begin
				if (skipping)
					complete(EV_BAD);
				else if (phase == PH_INIT)
					complete(EV_NOCERT);
				else if (phase == PH_WAIT)
					complete(EV_OK);
				else
					complete(EV_BAD);
				return;
			end
			c = ch;
			// after a bad escape only a newline matters
			if (skipping) begin
				if (c == CHAR_NL)
					complete(EV_BAD);
				return;
			end
			// percent escapes are finished whatever the mode is now
			if (esc_ph == ESC_FIRST) begin
				esc_hi_ch = c;
				esc_ph    = ESC_SECOND;
				return;
			end
			if (esc_ph == ESC_SECOND) begin
				hi     = hex_nibble(esc_hi_ch);
				lo     = hex_nibble(c);
				esc_ph = ESC_NONE;
				if (hi < 0 || lo < 0) begin
					skipping = 1'b1;
					return;
				end
				c        = {hi[3:0], lo[3:0]};
				from_esc = 1'b1;
			end else if (esc_mode) begin
				if (c == CHAR_PCT) begin
					esc_ph = ESC_FIRST;
					return;
				end
				if (c == CHAR_NL) begin
					complete(phase == PH_WAIT ? EV_OK : EV_BAD);
					return;
				end
			end
			case (phase)
				PH_INIT, PH_LINE: begin
					if (tag_idx > TAG_LAST || c != ARMOR_HDR[tag_idx])
						phase = PH_IDLE;
					else if (tag_idx == TAG_LAST)
						phase = PH_HEAD;
					else begin
						tag_idx++;
						phase = PH_LINE;
					end
				end
				PH_HEAD: if (c == CHAR_NL) phase = PH_Q0;
				PH_Q0, PH_Q1, PH_Q2, PH_Q3: begin
					sx = b64_index(c);
					if (c == CHAR_DASH)
						phase = PH_WAIT;
					else if (sx >= 0) begin
						v = sx[5:0];
						case (phase)
							PH_Q0: begin
								acc_bits = {v, 2'b00};
								phase    = PH_Q1;
							end
							PH_Q1: begin
								emit(acc_bits | {6'd0, v[5:4]});
								acc_bits = {v[3:0], 4'h0};
								phase    = PH_Q2;
							end
							PH_Q2: begin
								emit(acc_bits | {4'd0, v[5:2]});
								acc_bits = {v[1:0], 6'd0};
								phase    = PH_Q3;
							end
							default: begin
								emit(acc_bits | {2'd0, v});
								acc_bits = 8'h00;
								phase    = PH_Q0;
							end
						endcase
					end
				end
				PH_WAIT: if (c == CHAR_NL && !from_esc) complete(EV_OK);
				default: begin
					if (c == CHAR_NL) begin
						phase   = PH_LINE;
						tag_idx = 4'd0;
					end
				end
			endcase
		endfunction

		// compare one output beat with the oldest owed result
		function void check_result(logic [7:0] d, logic [1:0] e);
			cert_res_t want;
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected beat, expected none, actual data_byte %02h event_res %0d",
					$time, d, e);
				return;
			end
			want = pending_results.pop_front();
			if (d !== want.data) begin
				errors++;
				$display("%0t: data_byte mismatch, expected %02h, actual %02h",
					$time, want.data, d);
			end
			if (e !== want.ev) begin
				errors++;
				$display("%0t: event_res mismatch, expected %0d, actual %0d",
					$time, want.ev, e);
			end
		endfunction

		function int outstanding();
			return pending_results.size();
		endfunction
	endclass

	logic       clk           = 1'b0;
	logic       arst_n        = 1'b0;
	logic       in_valid      = 1'b0;
	logic       in_ready;
	logic [7:0] char_in       = 8'h00;
	logic       end_of_stream = 1'b0;
	logic       out_valid;
	logic       out_ready     = 1'b0;
	logic [7:0] data_byte;
	logic [1:0] event_res;
	logic       cfg_wr_en     = 1'b0;
	logic       cfg_wr_data   = 1'b0;

	cert_scoreboard sb = new();
	char_beat_t     beat_q[$];
	int             made_cnt    = 0;
	int             quiet_cycles = 0;
	bit             stall_req   = 1'b0;

	pem_base64_extractor DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.char_in      (char_in),
		.end_of_stream(end_of_stream),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.data_byte    (data_byte),
		.event_res    (event_res),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data)
	);

	always #1 clk = ~clk;

	// ---- stimulus building ----

	function automatic void put_char(logic [7:0] c);
		beat_q.push_back('{ch: c, eos: 1'b0});
		made_cnt++;
	endfunction

	function automatic void put_eos();
		beat_q.push_back('{ch: 8'($urandom_range(0, 255)), eos: 1'b1});
		made_cnt++;
	endfunction

	function automatic logic [7:0] hex_ascii(logic [3:0] n, bit lc);
		if (n < 4'd10) return 8'h30 + 8'(n);
		return (lc ? 8'h61 : 8'h41) + 8'(n) - 8'd10;
	endfunction

	// in escaped mode '%' and newline are always escaped, others now and then
	function automatic void put_enc(logic [7:0] c, bit esc);
		bit lc;
		lc = 1'($urandom_range(0, 1));
		if (esc && (c == CHAR_PCT || c == CHAR_NL || $urandom_range(0, 6) == 0)) begin
			put_char(CHAR_PCT);
			put_char(hex_ascii(c[7:4], lc));
			put_char(hex_ascii(c[3:0], lc));
		end else
			put_char(c);
	endfunction

	function automatic void put_text(string s, bit esc);
		int i;
		for (i = 0; i < s.len(); i++)
			put_enc(s[i], esc);
	endfunction

	function automatic logic [7:0] b64_char(int idx);
		if (idx < 26) return 8'("A" + idx);
		if (idx < 52) return 8'("a" + idx - 26);
		if (idx < 62) return 8'("0" + idx - 52);
		return (idx == 62) ? "+" : "/";
	endfunction

	function automatic void put_header(bit esc);
		put_text("-----BEGIN ", esc);
		repeat ($urandom_range(1, 6)) put_enc(8'($urandom_range(65, 90)), esc);
		put_text("-----", esc);
		put_enc(CHAR_NL, esc);
	endfunction

	// body text with line breaks and skipped characters mixed in
	function automatic void put_body(int n, bit esc);
		int i;
		for (i = 0; i < n; i++) begin
			if (i > 0 && i % 16 == 0) put_enc(CHAR_NL, esc);
			if ($urandom_range(0, 9) == 0) begin
				case ($urandom_range(0, 3))
					0: put_enc(" ", esc);
					1: put_enc("=", esc);
					2: put_enc(8'h09, esc);
					default: put_enc(8'h0D, esc);
				endcase
			end
			put_enc(b64_char($urandom_range(0, 63)), esc);
		end
	endfunction

	function automatic void make_cert(bit esc);
		repeat ($urandom_range(0, 2)) begin
			repeat ($urandom_range(1, 8)) put_enc(8'($urandom_range(32, 126)), esc);
			put_enc(CHAR_NL, esc);
		end
		put_header(esc);
		put_body($urandom_range(0, 40), esc);
		repeat ($urandom_range(0, 2)) put_enc("=", esc);
		put_enc(CHAR_NL, esc);
		put_text("-----END X-----", esc);
		if ($urandom_range(0, 9) == 0)
			put_eos();
		else
			put_char(CHAR_NL);
	endfunction

	function automatic void make_noise();
		repeat ($urandom_range(4, 16)) put_char(8'($urandom_range(0, 255)));
		if ($urandom_range(0, 2) == 0) put_eos();
	endfunction

	function automatic void make_broken(bit esc);
		case ($urandom_range(0, 3))
			// truncated block
			0: begin
				put_header(esc);
				put_body($urandom_range(0, 6), esc);
				put_eos();
			end
			// bad escape, or stream ending with an escape open
			1: begin
				put_body($urandom_range(0, 3), esc);
				put_char(CHAR_PCT);
				if ($urandom_range(0, 3) == 0)
					put_eos();
				else begin
					put_char(8'($urandom_range(103, 122)));
					put_char(8'($urandom_range(0, 255)));
					repeat ($urandom_range(0, 4)) put_char(8'($urandom_range(32, 126)));
					if ($urandom_range(0, 1) == 0)
						put_char(CHAR_NL);
					else
						put_eos();
				end
			end
			// escaped newline after the closing dash
			2: begin
				put_header(esc);
				put_body($urandom_range(0, 6), esc);
				put_char(CHAR_DASH);
				put_text("%0a", 1'b0);
				put_char("x");
				put_char(CHAR_NL);
			end
			// bare newline inside the body
			default: begin
				put_header(esc);
				put_body($urandom_range(1, 6), esc);
				put_char(CHAR_NL);
				put_char(CHAR_DASH);
				put_char(CHAR_NL);
			end
		endcase
	endfunction

	// ---- driving ----

	// offer queued beats in bursts with gaps; acceptance is read at the
	// falling edge, where valid and ready are settled for the next edge
	task automatic send_all();
		int burst_left;
		int gap_left;
		bit offered;
		burst_left = $urandom_range(1, 24);
		gap_left   = 0;
		offered    = 1'b0;
		while (beat_q.size() > 0 || offered) begin
			@(posedge clk);
			if (!offered) begin
				if (gap_left > 0) begin
					in_valid <= 1'b0;
					gap_left--;
				end else begin
					in_valid      <= 1'b1;
					char_in       <= beat_q[0].ch;
					end_of_stream <= beat_q[0].eos;
					offered = 1'b1;
					burst_left--;
					if (burst_left == 0) begin
						burst_left = $urandom_range(1, 24);
						gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
					end
				end
			end
			@(negedge clk);
			if (offered && in_ready) begin
				sb.note_char(beat_q[0].ch, beat_q[0].eos);
				void'(beat_q.pop_front());
				offered = 1'b0;
			end
		end
		@(posedge clk);
		in_valid <= 1'b0;
	endtask

	// wait for every owed result, then let beats with no result clear
	task automatic drain();
		while (sb.outstanding() > 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_mode(bit m);
		@(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= m;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		sb.esc_mode = m;
	endtask

	// receiver: randomly chosen stall patterns; long hold-off on request
	initial begin : rx_side
		int rx_cyc;
		int pat;
		rx_cyc = 0;
		pat    = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (stall_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES - 1) @(posedge clk);
				stall_req = 1'b0;
			end else begin
				if (rx_cyc % 50 == 0) pat = $urandom_range(0, 3);
				rx_cyc++;
				case (pat)
					0: out_ready <= 1'b1;
					1: out_ready <= 1'($urandom_range(0, 1));
					2: out_ready <= (rx_cyc % 4 != 0);
					default: out_ready <= ($urandom_range(0, 4) == 0);
				endcase
			end
		end
	end

	// output check and progress count
	always @(negedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				sb.check_result(data_byte, event_res);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
	end

	initial begin : watchdog
		wait (quiet_cycles >= WATCHDOG_LIMIT);
		$display("%0t: no beat accepted for %0d cycles", $time, quiet_cycles);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// ---- main sequence ----
	initial begin : main_seq
		int ph;
		int phase_start;
		int pick;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// directed: every event code, field extremes, header and all quartet slots
		write_mode(1'b0);
		put_eos();
		put_char(8'h00);
		put_char(8'hFF);
		put_eos();
		put_text("-----BEGIN \n//+A-\n", 1'b0);
		send_all();
		drain();

		// escape left open across a switch out of escaped mode
		write_mode(1'b1);
		put_char(CHAR_PCT);
		put_char("4");
		send_all();
		drain();
		write_mode(1'b0);
		put_char("1");
		put_eos();
		send_all();
		drain();

		// random phases, escaped mode alternating
		for (ph = 0; ph < 4; ph++) begin
			write_mode(ph % 2 == 0);
			if (ph == 0) stall_req = 1'b1;
			phase_start = made_cnt;
			while (made_cnt - phase_start < RAND_PHASE_BEATS) begin
				pick = $urandom_range(0, 9);
				if (pick < 7)
					make_cert(sb.esc_mode);
				else if (pick < 9)
					make_broken(sb.esc_mode);
				else
					make_noise();
			end
			send_all();
			drain();
		end

		if (sb.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/pem_b64_pkg.sv
rtl/pem_b64_core.sv
rtl/pem_b64_outreg.sv
rtl/pem_base64_extractor.sv
tb/tb_pem_base64_extractor.sv
